FILE: rtl/mesh_bounding_sphere_normalize_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mesh bounding sphere normalize unit
// Same-cycle and next-cycle implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef MESH_BOUNDING_SPHERE_NORMALIZE_UNIT_ASSERT_SVH
`define MESH_BOUNDING_SPHERE_NORMALIZE_UNIT_ASSERT_SVH

`define MBSN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbsn: same-cycle check failed");

`define MBSN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbsn: next-cycle check failed");

`endif

FILE: rtl/mbsn_pkg.sv
// ----------------------------------------------------------------------------
// mbsn_pkg
// Shared types and constants of the mesh bounding sphere normalize unit.
// ----------------------------------------------------------------------------
package mbsn_pkg;

    localparam int unsigned JOB_CNT_W = 7;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic REG_TARGET_RADIUS = 1'b0;
    localparam logic [31:0] TARGET_RADIUS_RST = 32'h0001_0000;

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] t_coord;

    typedef struct packed {
        t_coord                 cx;
        t_coord                 cy;
        t_coord                 cz;
        logic [JOB_CNT_W-1:0]   count;
        logic                   dropped;
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_bstat;

    typedef enum logic [1:0] {
        F_LOAD,
        F_CLOSE,
        F_WAIT
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_RWAIT,
        B_SQ,
        B_ACC,
        B_CMP,
        B_SQINIT,
        B_SQRT,
        B_SWAIT,
        B_MUL,
        B_DIV,
        B_SAT,
        B_EMIT
    } t_back_state;

endpackage

FILE: rtl/mbsn_intf.sv
// ----------------------------------------------------------------------------
// mbsn channel interfaces
// Vertex input channel and normalized result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbsn_vtx_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_in;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output last_in, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input last_in, output ready);
endinterface

interface mbsn_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_out;
    logic               overflow;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output last_out, output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input last_out, input overflow, output ready);
endinterface

FILE: rtl/mesh_bounding_sphere_normalize_unit.sv
// ----------------------------------------------------------------------------
// mesh_bounding_sphere_normalize_unit
// Normalizes a run of Q16.16 vertices into a sphere of programmable radius.
// ----------------------------------------------------------------------------
// Vertices enter on i_vtx, one transaction per cycle while loading; the
// transaction with last_in closes the run. Up to MAX_VERTICES are stored,
// further ones are dropped and flag overflow on every result of the run.
// After the close, the back end scans the store, takes the square root,
// then per vertex runs one multiply and a restoring divide per axis, with
// the divide skipped when the radius is zero. Results leave on o_res in
// load order, last_out on the final one. The shared divider sets the
// output rate. i_vtx stays not ready from the close until the last result
// has entered the output register. A stall on o_res holds the back end in
// place; nothing is lost. target_radius is written over the APB port at
// byte address 0. Synchronous reset empties the run, the job queue and the
// output register and sets target_radius to 1.0.
// ----------------------------------------------------------------------------
`include "mesh_bounding_sphere_normalize_unit_assert.svh"

module mesh_bounding_sphere_normalize_unit
    import mbsn_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbsn_vtx_if.sink    i_vtx,
    mbsn_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    logic [31:0]   r_target_radius;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [95:0]   w_wdata;
    logic [95:0]   w_rdata;
    logic          w_push;
    logic          w_pop;
    logic          w_qvalid;
    logic          w_qfull;
    t_job          w_job_in;
    t_job          w_job_out;
    t_bstat        w_bstat;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TARGET_RADIUS);
    assign prdata   = (paddr[2] == REG_TARGET_RADIUS) ? r_target_radius : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_radius <= TARGET_RADIUS_RST;
        end else if (w_cfg_wr) begin
            r_target_radius <= pwdata;
        end
    end

    mbsn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (i_vtx),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_qfull (w_qfull),
        .i_bstat (w_bstat)
    );

    mbsn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mbsn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_valid (w_qvalid),
        .o_full  (w_qfull)
    );

    mbsn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (w_qvalid),
        .i_job    (w_job_out),
        .o_pop    (w_pop),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata),
        .i_target (r_target_radius),
        .o_bstat  (w_bstat),
        .o_res    (o_res)
    );

    `MBSN_ASSERT_NOW(a_no_load_while_busy, i_clk, i_rst_n, i_vtx.valid && i_vtx.ready, !w_bstat.busy)
    `MBSN_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, w_push, !w_qfull)
    `MBSN_ASSERT_NEXT(a_cfg_write_lands, i_clk, i_rst_n, w_cfg_wr, r_target_radius == $past(pwdata))

endmodule

FILE: rtl/mbsn_ram.sv
// ----------------------------------------------------------------------------
// mbsn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbsn_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mbsn_queue.sv
// ----------------------------------------------------------------------------
// mbsn_queue
// Two-entry job queue between the load front end and the normalize back end.
// ----------------------------------------------------------------------------
module mbsn_queue
    import mbsn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_valid,
    output logic o_full
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

FILE: rtl/mbsn_front.sv
// ----------------------------------------------------------------------------
// mbsn_front
// Accepts vertices, fills the store, tracks bounds and closes each run.
// ----------------------------------------------------------------------------
module mbsn_front
    import mbsn_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbsn_vtx_if.sink          i_vtx,
    output logic              o_we,
    output logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] o_waddr,
    output logic [95:0]       o_wdata,
    output logic              o_push,
    output t_job              o_job,
    input  logic              i_qfull,
    input  t_bstat            i_bstat
);

    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    t_front_state    r_state, n_state;
    logic [CW-1:0]   r_count;
    logic            r_dropped;
    t_coord          r_min [3];
    t_coord          r_max [3];
    t_coord          pos   [3];
    t_coord          ctr   [3];
    logic signed [32:0] sum [3];
    logic            acc;
    logic            full;
    logic            clear;

    always_comb begin
        pos[0] = i_vtx.pos_x;
        pos[1] = i_vtx.pos_y;
        pos[2] = i_vtx.pos_z;
        for (int a = 0; a < 3; a++) begin
            sum[a] = {r_min[a][31], r_min[a]} + {r_max[a][31], r_max[a]};
            ctr[a] = sum[a][32:1];
        end
    end

    assign i_vtx.ready = (r_state == F_LOAD);
    assign acc         = i_vtx.valid && i_vtx.ready;
    assign full        = (r_count == CW'(MAX_VERTICES));
    assign o_we        = acc && !full;
    assign o_waddr     = r_count[AW-1:0];
    assign o_wdata     = {i_vtx.pos_x, i_vtx.pos_y, i_vtx.pos_z};

    assign o_job.cx      = ctr[0];
    assign o_job.cy      = ctr[1];
    assign o_job.cz      = ctr[2];
    assign o_job.count   = JOB_CNT_W'(r_count);
    assign o_job.dropped = r_dropped;

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        clear   = 1'b0;
        case (r_state)
            F_LOAD: begin
                if (acc && i_vtx.last_in) begin
                    n_state = F_CLOSE;
                end
            end
            F_CLOSE: begin
                if (!i_qfull) begin
                    o_push  = 1'b1;
                    clear   = 1'b1;
                    n_state = F_WAIT;
                end
            end
            F_WAIT: begin
                if (i_bstat.done) begin
                    n_state = F_LOAD;
                end
            end
            default: begin
                n_state = F_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= COORD_MAX;
                r_max[a] <= COORD_MIN;
            end
        end else if (acc) begin
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
                for (int a = 0; a < 3; a++) begin
                    if (pos[a] < r_min[a]) begin
                        r_min[a] <= pos[a];
                    end
                    if (pos[a] > r_max[a]) begin
                        r_max[a] <= pos[a];
                    end
                end
            end
        end
    end

endmodule

FILE: rtl/mbsn_back.sv
// ----------------------------------------------------------------------------
// mbsn_back
// Finds the bounding radius; if nonzero, scales each vertex of a closed run.
// ----------------------------------------------------------------------------
module mbsn_back
    import mbsn_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_qvalid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic [((MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1)-1:0] o_raddr,
    input  logic [95:0]       i_rdata,
    input  logic [31:0]       i_target,
    output t_bstat            o_bstat,
    mbsn_res_if.source        o_res
);

    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

    t_back_state     r_state, n_state;
    t_job            r_job;
    logic [CW-1:0]   r_idx;
    logic [1:0]      r_axis;
    logic [5:0]      r_iter;
    logic [63:0]     r_prod;
    logic [63:0]     r_sum;
    logic [63:0]     r_best;
    logic [33:0]     r_rem;
    logic [31:0]     r_root;
    logic [63:0]     r_div;
    logic [31:0]     r_drem;
    logic            r_neg;
    t_coord          r_res [3];
    logic            r_ovalid;
    t_coord          r_ox, r_oy, r_oz;
    logic            r_olast, r_oovf;

    t_coord          p, c;
    logic signed [32:0] off;
    logic [32:0]     mag33;
    logic [31:0]     mag;
    logic [31:0]     mul_b;
    logic [63:0]     prod;
    logic [35:0]     sq_tmp, sq_trial;
    logic            sq_ge;
    logic [32:0]     dv_tmp;
    logic            dv_ge;
    t_coord          sat;
    logic [CW-1:0]   last_idx;
    logic            is_last;
    logic            slot_free;

    always_comb begin
        case (r_axis)
            AX_X: begin
                p = i_rdata[95:64];
                c = r_job.cx;
            end
            AX_Y: begin
                p = i_rdata[63:32];
                c = r_job.cy;
            end
            default: begin
                p = i_rdata[31:0];
                c = r_job.cz;
            end
        endcase
        off      = {p[31], p} - {c[31], c};
        mag33    = off[32] ? 33'(-off) : 33'(off);
        mag      = mag33[31:0];
        mul_b    = (r_state == B_SQ) ? mag : i_target;
        prod     = 64'(mag) * 64'(mul_b);
        sq_tmp   = {r_rem, r_sum[63:62]};
        sq_trial = {2'b00, r_root, 2'b01};
        sq_ge    = (sq_tmp >= sq_trial);
        dv_tmp   = {r_drem, r_div[63]};
        dv_ge    = (dv_tmp >= {1'b0, r_root});
        if (r_neg) begin
            sat = (r_div > 64'h8000_0000) ? COORD_MIN : t_coord'(-r_div[31:0]);
        end else begin
            sat = (r_div > 64'h7FFF_FFFF) ? COORD_MAX : t_coord'(r_div[31:0]);
        end
        last_idx  = CW'(r_job.count) - 1'b1;
        is_last   = (r_idx == last_idx);
        slot_free = !r_ovalid || o_res.ready;
    end

    assign o_raddr = r_idx[AW-1:0];

    always_comb begin
        n_state      = r_state;
        o_pop        = 1'b0;
        o_bstat.busy = (r_state != B_IDLE);
        o_bstat.done = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_qvalid) begin
                    o_pop   = 1'b1;
                    n_state = B_RWAIT;
                end
            end
            B_RWAIT:  n_state = B_SQ;
            B_SQ:     n_state = B_ACC;
            B_ACC:    n_state = (r_axis == AX_Z) ? B_CMP : B_SQ;
            B_CMP:    n_state = is_last ? B_SQINIT : B_RWAIT;
            B_SQINIT: n_state = B_SQRT;
            B_SQRT: begin
                if (r_iter == 6'd31) begin
                    n_state = B_SWAIT;
                end
            end
            B_SWAIT:  n_state = B_MUL;
            B_MUL: begin
                if (r_root == 32'd0) begin
                    n_state = (r_axis == AX_Z) ? B_EMIT : B_MUL;
                end else begin
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (r_iter == 6'd63) begin
                    n_state = B_SAT;
                end
            end
            B_SAT:    n_state = (r_axis == AX_Z) ? B_EMIT : B_MUL;
            B_EMIT: begin
                if (slot_free) begin
                    if (is_last) begin
                        o_bstat.done = 1'b1;
                        n_state      = B_IDLE;
                    end else begin
                        n_state = B_SWAIT;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_EMIT && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job  <= i_job;
                r_idx  <= '0;
                r_axis <= AX_X;
                r_sum  <= '0;
                r_best <= '0;
            end
            B_SQ: begin
                r_prod <= prod;
            end
            B_ACC: begin
                r_sum  <= r_sum + r_prod;
                r_axis <= r_axis + 2'd1;
            end
            B_CMP: begin
                if (r_sum > r_best) begin
                    r_best <= r_sum;
                end
                r_sum  <= '0;
                r_axis <= AX_X;
                if (!is_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            B_SQINIT: begin
                r_sum  <= r_best;
                r_rem  <= '0;
                r_root <= '0;
                r_iter <= '0;
            end
            B_SQRT: begin
                r_sum  <= {r_sum[61:0], 2'b00};
                r_iter <= r_iter + 6'd1;
                if (sq_ge) begin
                    r_rem  <= 34'(sq_tmp - sq_trial);
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= sq_tmp[33:0];
                    r_root <= {r_root[30:0], 1'b0};
                end
                if (r_iter == 6'd31) begin
                    r_idx  <= '0;
                    r_axis <= AX_X;
                end
            end
            B_MUL: begin
                r_neg  <= off[32];
                r_div  <= prod;
                r_drem <= '0;
                r_iter <= '0;
                if (r_root == 32'd0) begin
                    r_res[r_axis] <= p;
                    r_axis        <= r_axis + 2'd1;
                end
            end
            B_DIV: begin
                r_iter <= r_iter + 6'd1;
                if (dv_ge) begin
                    r_drem <= 32'(dv_tmp - {1'b0, r_root});
                    r_div  <= {r_div[62:0], 1'b1};
                end else begin
                    r_drem <= dv_tmp[31:0];
                    r_div  <= {r_div[62:0], 1'b0};
                end
            end
            B_SAT: begin
                r_res[r_axis] <= sat;
                r_axis        <= r_axis + 2'd1;
            end
            B_EMIT: begin
                if (slot_free) begin
                    r_ox    <= r_res[0];
                    r_oy    <= r_res[1];
                    r_oz    <= r_res[2];
                    r_olast <= is_last;
                    r_oovf  <= r_job.dropped;
                    r_axis  <= AX_X;
                    if (!is_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid    = r_ovalid;
    assign o_res.out_x    = r_ox;
    assign o_res.out_y    = r_oy;
    assign o_res.out_z    = r_oz;
    assign o_res.last_out = r_olast;
    assign o_res.overflow = r_oovf;

endmodule

FILE: bench/mbsn_tb_pkg.sv
// ----------------------------------------------------------------------------
// mbsn_tb_pkg
// Vertex and result records used by the mesh normalize testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package mbsn_tb_pkg;

    import mbsn_pkg::*;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
    } t_vertex;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   last;
        logic   ovf;
    } t_norm;

endpackage

FILE: bench/tb_mesh_bounding_sphere_normalize_unit.sv
// ----------------------------------------------------------------------------
// tb_mesh_bounding_sphere_normalize_unit
// Drives directed vertex runs and runs of random size and shape through the
// normalize unit under several target radii and handshake pressure levels,
// predicts each run's normalized positions, compares them field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mesh_bounding_sphere_normalize_unit;

    import mbsn_pkg::*;
    import mbsn_tb_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int WDOG_MAX  = 200000;
    localparam logic [2:0] ADDR_TARGET_RADIUS = {REG_TARGET_RADIUS, 2'b00};

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mbsn_vtx_if vtx ();
    mbsn_res_if res ();

    mesh_bounding_sphere_normalize_unit #(.MAX_VERTICES(CAPACITY)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx.sink),
        .o_res   (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_vertex     pending_vtx[$];
    t_norm       expected_norm[$];
    int          fail_cnt;
    int          idle_pct;
    int          stall_pct;
    int          wdog;
    logic        vtx_acc;

    // predictor state
    logic [31:0] radius_reg;
    t_coord      vtx_mem[CAPACITY][3];
    int          run_cnt;
    logic signed [32:0] lo[3];
    logic signed [32:0] hi[3];
    logic        run_dropped;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_coord scale_offset(input logic signed [33:0] off,
                                            input logic [63:0] rad);
        logic [63:0] mag;
        logic [63:0] q;
        mag = off < 0 ? 64'(-off) : 64'(off);
        q = (mag * 64'(radius_reg)) / rad;
        if (off < 0) begin
            if (q > (64'd1 << 31)) return COORD_MIN;
            return t_coord'(-q);
        end
        if (q > 64'h7FFF_FFFF) return COORD_MAX;
        return t_coord'(q);
    endfunction

    task automatic clear_run();
        run_cnt = 0;
        run_dropped = 1'b0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = 33'(COORD_MAX);
            hi[a] = 33'(COORD_MIN);
        end
    endtask

    task automatic predict_vertex(input t_vertex v);
        t_coord p[3];
        logic signed [33:0] ctr[3];
        logic signed [33:0] s;
        logic signed [33:0] o;
        logic [63:0] best;
        logic [63:0] d2;
        logic [63:0] m;
        logic [63:0] rad;
        t_norm n;
        p[0] = v.x;
        p[1] = v.y;
        p[2] = v.z;
        if (run_cnt < CAPACITY) begin
            for (int a = 0; a < 3; a++) begin
                if (p[a] < lo[a]) lo[a] = 33'(p[a]);
                if (p[a] > hi[a]) hi[a] = 33'(p[a]);
            end
            vtx_mem[run_cnt] = '{p[0], p[1], p[2]};
            run_cnt++;
        end else begin
            run_dropped = 1'b1;
        end
        if (!v.last) return;
        for (int a = 0; a < 3; a++) begin
            s = 34'(lo[a]) + 34'(hi[a]);
            ctr[a] = s >>> 1;
        end
        best = 0;
        for (int i = 0; i < run_cnt; i++) begin
            d2 = 0;
            for (int a = 0; a < 3; a++) begin
                o = 34'(vtx_mem[i][a]) - ctr[a];
                m = o < 0 ? 64'(-o) : 64'(o);
                d2 = d2 + m * m;
            end
            if (d2 > best) best = d2;
        end
        rad = isqrt(best);
        for (int i = 0; i < run_cnt; i++) begin
            if (rad == 0) begin
                n.x = vtx_mem[i][0];
                n.y = vtx_mem[i][1];
                n.z = vtx_mem[i][2];
            end else begin
                n.x = scale_offset(34'(vtx_mem[i][0]) - ctr[0], rad);
                n.y = scale_offset(34'(vtx_mem[i][1]) - ctr[1], rad);
                n.z = scale_offset(34'(vtx_mem[i][2]) - ctr[2], rad);
            end
            n.last = (i + 1 == run_cnt);
            n.ovf = run_dropped;
            expected_norm = {expected_norm, n};
        end
        clear_run();
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            vtx.valid <= 1'b0;
        end else if (!vtx.valid || vtx_acc) begin
            if (pending_vtx.size() != 0 && $urandom_range(99) >= idle_pct) begin
                vtx.valid   <= 1'b1;
                vtx.pos_x   <= pending_vtx[0].x;
                vtx.pos_y   <= pending_vtx[0].y;
                vtx.pos_z   <= pending_vtx[0].z;
                vtx.last_in <= pending_vtx[0].last;
            end else begin
                vtx.valid <= 1'b0;
            end
        end
        res.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_norm e;
        vtx_acc <= i_rst_n && vtx.valid && vtx.ready;
        if (i_rst_n) begin
            if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
                wdog <= 0;
            end else begin
                wdog <= wdog + 1;
            end
            if (vtx.valid && vtx.ready) begin
                predict_vertex(pending_vtx.pop_front());
            end
            if (res.valid && res.ready) begin
                if (expected_norm.size() == 0) begin
                    $error("unexpected result x=%0d", res.out_x);
                    fail_cnt++;
                end else begin
                    e = expected_norm.pop_front();
                    if (res.out_x !== e.x) begin
                        $error("out_x exp %0d got %0d", e.x, res.out_x);
                        fail_cnt++;
                    end
                    if (res.out_y !== e.y) begin
                        $error("out_y exp %0d got %0d", e.y, res.out_y);
                        fail_cnt++;
                    end
                    if (res.out_z !== e.z) begin
                        $error("out_z exp %0d got %0d", e.z, res.out_z);
                        fail_cnt++;
                    end
                    if (res.last_out !== e.last) begin
                        $error("last_out exp %0b got %0b", e.last, res.last_out);
                        fail_cnt++;
                    end
                    if (res.overflow !== e.ovf) begin
                        $error("overflow exp %0b got %0b", e.ovf, res.overflow);
                        fail_cnt++;
                    end
                end
            end
            if (wdog >= WDOG_MAX) begin
                $display("** mesh_bounding_sphere_normalize_unit: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_radius(input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TARGET_RADIUS;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        radius_reg = val;
    endtask

    task automatic drain();
        while (pending_vtx.size() != 0 || expected_norm.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_coord rand_coord(input int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(8000) - 4000) <<< 8;
            2: return ($urandom_range(1)) ? COORD_MAX : COORD_MIN;
            default: return t_coord'($urandom_range(200) - 100);
        endcase
    endfunction

    task automatic push_vertex(input t_coord x, input t_coord y, input t_coord z,
                               input logic last);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.last = last;
        pending_vtx = {pending_vtx, v};
    endtask

    task automatic random_run(input int len);
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++)
            push_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                        i == len - 1);
    endtask

    initial begin
        int loaded;
        logic [31:0] radii[6];
        vtx.valid = 1'b0;
        vtx.pos_x = '0;
        vtx.pos_y = '0;
        vtx.pos_z = '0;
        vtx.last_in = 1'b0;
        res.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_cnt = 0;
        idle_pct = 0;
        stall_pct = 0;
        wdog = 0;
        radius_reg = TARGET_RADIUS_RST;
        clear_run();
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single vertex, coincident run, extremes, zero radius, overflow
        push_vertex(32'sd5, -32'sd7, 32'sd9, 1'b1);
        push_vertex(32'sd100, 32'sd100, 32'sd100, 1'b0);
        push_vertex(32'sd100, 32'sd100, 32'sd100, 1'b1);
        push_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        push_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        push_vertex(32'sd0, -32'sd1, 32'sd1, 1'b1);
        push_vertex(-32'sd65536, 32'sd0, 32'sd0, 1'b0);
        push_vertex(32'sd65536, 32'sd3, -32'sd3, 1'b1);
        drain();
        write_radius(32'h0000_0000);
        push_vertex(32'sd7, 32'sd1, -32'sd9, 1'b0);
        push_vertex(-32'sd70000, 32'sd2, 32'sd4, 1'b1);
        drain();
        write_radius(32'hFFFF_FFFF);
        push_vertex(32'sd1, 32'sd0, 32'sd0, 1'b0);
        push_vertex(-32'sd1, 32'sd0, 32'sd0, 1'b0);
        push_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
        drain();
        write_radius(TARGET_RADIUS_RST);
        for (int i = 0; i < CAPACITY + 3; i++)
            push_vertex(rand_coord(3), rand_coord(3), rand_coord(3), i == CAPACITY + 2);
        drain();

        radii = '{32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0064_0000, 32'h8000_0000};
        loaded = 0;
        for (int ph = 0; ph < 8; ph++) begin
            write_radius(ph < 6 ? radii[ph] : $urandom);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            while (loaded < (ph + 1) * 48) begin
                int len;
                len = ($urandom_range(19) == 0) ? $urandom_range(66, 60)
                                                 : $urandom_range(6, 1);
                random_run(len);
                loaded += len;
            end
            drain();
        end

        if (fail_cnt == 0) begin
            $display("** mesh_bounding_sphere_normalize_unit: PASSED **");
        end else begin
            $display("** mesh_bounding_sphere_normalize_unit: FAILED **");
        end
        $finish;
    end

endmodule
